// ===== rtl/fcba_pkg.sv =====
// Package for the block allocator: table geometry, link codes, operation and status
// codes, and the command and status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fcba_pkg;

  localparam int NUM_BLOCKS = 65536;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = 16;
  localparam int CNT_W      = 17;

  localparam logic [CNT_W-1:0]  BLK_LIMIT  = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0]  CLEAR_LAST = CNT_W'(NUM_BLOCKS - 1);
  localparam logic [LINK_W-1:0] FREE_RESET = LINK_W'(NUM_BLOCKS - 1);

  localparam logic [LINK_W-1:0] LINK_EMPTY = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_END   = 16'hFFFF;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_SET   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;

  typedef struct packed {
    logic clear;
    logic capture;
    logic exec;
    logic walk;
    logic scan;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic to_walk;
    logic to_scan;
    logic walk_end;
    logic scan_end;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fcba_if.sv =====
// Handshake channel interfaces for the block allocator: request and result.
// Depend on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface fcba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] block_index;
  logic [15:0] link_value;

  modport source (output valid, func, block_index, link_value, input ready);
  modport sink   (input valid, func, block_index, link_value, output ready);
endinterface

interface fcba_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] allocated_block;
  logic [15:0] link_read;
  logic [15:0] free_count;
  logic [1:0]  status;

  modport source (output valid, allocated_block, link_read, free_count, status,
                  input ready);
  modport sink   (input valid, allocated_block, link_read, free_count, status,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/fcba_ctrl.sv =====
// Controller state machine of the block allocator.
// Depends on fcba_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fcba_ctrl import fcba_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        priority if (sts.to_walk) state_nxt = S_WALK;
        else if (sts.to_scan)     state_nxt = S_SCAN;
        else                      state_nxt = S_DONE;
      end
      S_WALK:  if (sts.walk_end) state_nxt = S_DONE;
      S_SCAN:  if (sts.scan_end) state_nxt = S_DONE;
      S_DONE:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.clear   = (state_r == S_CLEAR);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.walk    = (state_r == S_WALK);
  assign cmd.scan    = (state_r == S_SCAN);
  assign cmd.load    = (state_r == S_DONE) && sts.out_free;

endmodule

`default_nettype wire

// ===== rtl/fcba_dp.sv =====
// Datapath of the block allocator: link table memory, hint and free count,
// walk and scan counters, and the result register.
// Depends on fcba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcba_dp import fcba_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire logic [1:0]        in_func,
  input  wire logic [LINK_W-1:0] in_block_index,
  input  wire logic [LINK_W-1:0] in_link_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [LINK_W-1:0]      out_allocated_block,
  output logic [LINK_W-1:0]      out_link_read,
  output logic [LINK_W-1:0]      out_free_count,
  output logic [1:0]             out_status
);

  logic [LINK_W-1:0] mem [NUM_BLOCKS];
  logic [LINK_W-1:0] rdata_r;

  logic [1:0]        func_r;
  logic [LINK_W-1:0] idx_r, val_r, old_r, alloc_r, pos_r;
  logic              ok_r;
  logic [1:0]        status_r;
  logic [CNT_W-1:0]  hint_r, cnt_r;
  logic [LINK_W-1:0] unused_r;

  logic [LINK_W-1:0] out_alloc_r, out_link_r, out_free_r;
  logic [1:0]        out_status_r;
  logic              out_valid_r;

  logic              we;
  logic [LINK_W-1:0] waddr, wdata, raddr;

  logic ok_in, is_alloc, full, alloc_go, set_go, set_free, set_take, set_scan;
  logic nxt_ok, walk_wr, scan_hit;
  logic [LINK_W-1:0] unused_inc;

  assign ok_in    = (in_block_index != '0) && ({1'b0, in_block_index} < BLK_LIMIT);
  assign is_alloc = (func_r == FUNC_ALLOC);
  assign full     = (hint_r >= BLK_LIMIT) || (unused_r == '0);
  assign alloc_go = is_alloc && !full;
  assign set_go   = (func_r == FUNC_SET) && ok_r;
  assign set_free = set_go && (rdata_r != LINK_EMPTY) && (val_r == LINK_EMPTY);
  assign set_take = set_go && (rdata_r == LINK_EMPTY) && (val_r != LINK_EMPTY);
  assign set_scan = set_take && ({1'b0, idx_r} == hint_r);
  assign nxt_ok   = (rdata_r != '0) && ({1'b0, rdata_r} < BLK_LIMIT);
  assign walk_wr  = (rdata_r != LINK_EMPTY);
  assign scan_hit = (cnt_r >= BLK_LIMIT) || (rdata_r == LINK_EMPTY);
  assign unused_inc = (unused_r != 16'hFFFF) ? unused_r + 16'd1 : unused_r;

  assign sts.clear_last = (cnt_r == CLEAR_LAST);
  assign sts.to_walk    = (func_r == FUNC_FREE) && ok_r;
  assign sts.to_scan    = alloc_go || set_scan;
  assign sts.walk_end   = !walk_wr || (rdata_r == LINK_END) || (rdata_r == pos_r) || !nxt_ok;
  assign sts.scan_end   = scan_hit;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = LINK_EMPTY;
    raddr = idx_r;
    priority if (cmd.clear) begin
      we    = 1'b1;
      waddr = cnt_r[LINK_W-1:0];
    end else if (cmd.capture) begin
      raddr = in_block_index;
    end else if (cmd.exec) begin
      if (alloc_go) begin
        we    = 1'b1;
        waddr = hint_r[LINK_W-1:0];
        wdata = LINK_END;
        raddr = hint_r[LINK_W-1:0] + 16'd1;
      end else if (set_go) begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = val_r;
        raddr = idx_r + 16'd1;
      end
    end else if (cmd.walk) begin
      we    = walk_wr;
      waddr = pos_r;
      raddr = rdata_r;
    end else if (cmd.scan) begin
      raddr = cnt_r[LINK_W-1:0] + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[ADDR_W-1:0]] <= wdata;
    end
    rdata_r <= mem[raddr[ADDR_W-1:0]];
  end

  // Operation registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      idx_r  <= in_block_index;
      val_r  <= in_link_value;
      ok_r   <= ok_in;
    end
    if (cmd.exec) begin
      old_r    <= ok_r ? rdata_r : '0;
      alloc_r  <= alloc_go ? hint_r[LINK_W-1:0] : '0;
      status_r <= is_alloc ? (full ? ST_FULL : ST_OK) : (ok_r ? ST_OK : ST_BAD_IDX);
      pos_r    <= idx_r;
    end else if (cmd.walk) begin
      pos_r <= rdata_r;
    end
    if (cmd.load) begin
      out_alloc_r  <= alloc_r;
      out_link_r   <= old_r;
      out_free_r   <= unused_r;
      out_status_r <= status_r;
    end
  end

  // Allocator state and control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hint_r      <= CNT_W'(1);
      unused_r    <= FREE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.exec) begin
        if (alloc_go) begin
          unused_r <= unused_r - 16'd1;
          cnt_r    <= hint_r + 1'b1;
        end else if (set_free) begin
          unused_r <= unused_inc;
          if ({1'b0, idx_r} < hint_r) hint_r <= {1'b0, idx_r};
        end else if (set_take) begin
          if (unused_r != '0) unused_r <= unused_r - 16'd1;
          cnt_r <= {1'b0, idx_r} + 1'b1;
        end
      end else if (cmd.walk) begin
        if (walk_wr) begin
          unused_r <= unused_inc;
          if ({1'b0, pos_r} < hint_r) hint_r <= {1'b0, pos_r};
        end
      end else if (cmd.scan) begin
        if (scan_hit) begin
          hint_r <= cnt_r;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end

      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_alloc_r;
  assign out_link_read       = out_link_r;
  assign out_free_count      = out_free_r;
  assign out_status          = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/fat_chain_block_allocator.sv =====
// Top level of the chained block allocator: controller, datapath and channel hookup.
// Depends on fcba_pkg, fcba_if, fcba_ctrl and fcba_dp.
// Each operation goes through execute and, as needed, a walk or a scan before its result
// goes to the output register: a read, a bad index, a full allocate or a set that leaves
// the hint need neither, allocate scans table entries, set scans when the hint moves, and
// free walks the chain entry by entry. One item is in work at a time, and the next input
// transfer is taken while the previous result waits. Synchronous reset starts a clearing
// pass over the whole link table, with ready low, before the first item.
`timescale 1ns / 1ps
`default_nettype none

module fat_chain_block_allocator import fcba_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcba_in_if.sink    in_chan,
  fcba_out_if.source out_chan
);

  // The controller sequences each operation through execute, walk or scan steps and
  // hands the finished result to the output register once that register is free.
  dp_cmd_t cmd;
  dp_sts_t sts;

  fcba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the link table. A chain walk and a free-slot scan each step one
  // table entry per cycle, limited by the single registered read port of the memory.
  fcba_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_chan.func),
    .in_block_index      (in_chan.block_index),
    .in_link_value       (in_chan.link_value),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_allocated_block (out_chan.allocated_block),
    .out_link_read       (out_chan.link_read),
    .out_free_count      (out_chan.free_count),
    .out_status          (out_chan.status)
  );

endmodule

`default_nettype wire

// ===== tb/fcba_result_checker.sv =====
// Result checker for the block allocator: watches both channels, keeps its own link table,
// hint and free count, and compares each result transfer with the oldest expectation.
// Depends on fcba_pkg and fcba_if.
`timescale 1ns / 1ps

module fcba_result_checker import fcba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fcba_in_if   in_mon,
  fcba_out_if  out_mon,
  output int   error_count,
  output int   pending_results
);

  typedef struct packed {
    logic [15:0] allocated_block;
    logic [15:0] link_read;
    logic [15:0] free_count;
    logic [1:0]  status;
  } alloc_result_t;

  logic [LINK_W-1:0] link_tbl [NUM_BLOCKS];
  int unsigned       hint;
  int unsigned       unused;
  alloc_result_t     awaited_results [$];
  int                errs;
  int                result_no;

  function automatic bit index_valid(input int unsigned i);
    return i != 0 && i < NUM_BLOCKS;
  endfunction

  // Lowest empty entry at or above start, NUM_BLOCKS when there is none.
  function automatic int unsigned next_empty(input int unsigned start);
    int unsigned i;
    i = start;
    while (i < NUM_BLOCKS && link_tbl[i] != LINK_EMPTY) i++;
    return i;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s: got %0d, expected %0d", result_no, what, got, want);
    errs++;
  endtask

  task automatic apply_request(input logic [1:0] op, input logic [15:0] idx,
                               input logic [15:0] val);
    alloc_result_t r;
    bit            in_range;
    bit            walking;
    int unsigned   ix;
    int unsigned   pos;
    logic [15:0]   nxt;
    logic [15:0]   prior;
    ix       = idx;
    in_range = index_valid(ix);
    prior    = in_range ? link_tbl[ix] : LINK_EMPTY;
    r        = '0;
    r.link_read = prior;
    if (op == FUNC_ALLOC) begin
      if (hint >= NUM_BLOCKS || hint == 0 || unused == 0) begin
        r.status = ST_FULL;
      end else begin
        link_tbl[hint]    = LINK_END;
        unused            = unused - 1;
        r.allocated_block = hint[15:0];
        hint              = next_empty(hint + 1);
      end
    end else if (!in_range) begin
      r.status = ST_BAD_IDX;
    end else if (op == FUNC_FREE) begin
      // Every visited entry is emptied, so a looping chain runs into an empty entry.
      pos     = ix;
      walking = 1'b1;
      while (walking && index_valid(pos)) begin
        nxt = link_tbl[pos];
        if (nxt == LINK_EMPTY) begin
          walking = 1'b0;
        end else begin
          link_tbl[pos] = LINK_EMPTY;
          if (unused < 'hFFFF) unused = unused + 1;
          if (pos < hint) hint = pos;
          if (nxt == LINK_END) walking = 1'b0;
          else pos = nxt;
        end
      end
    end else if (op == FUNC_SET) begin
      link_tbl[ix] = val;
      if (prior != LINK_EMPTY && val == LINK_EMPTY) begin
        if (unused < 'hFFFF) unused = unused + 1;
        if (ix < hint) hint = ix;
      end else if (prior == LINK_EMPTY && val != LINK_EMPTY) begin
        if (unused > 0) unused = unused - 1;
        if (ix == hint) hint = next_empty(ix + 1);
      end
    end
    r.free_count = unused[15:0];
    awaited_results.push_back(r);
  endtask

  task automatic check_result();
    alloc_result_t w;
    result_no++;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with no request outstanding", out_mon.free_count, 0);
    end else begin
      w = awaited_results.pop_front();
      if (out_mon.allocated_block !== w.allocated_block)
        report_mismatch("allocated_block", out_mon.allocated_block, w.allocated_block);
      if (out_mon.link_read !== w.link_read)
        report_mismatch("link_read", out_mon.link_read, w.link_read);
      if (out_mon.free_count !== w.free_count)
        report_mismatch("free_count", out_mon.free_count, w.free_count);
      if (out_mon.status !== w.status)
        report_mismatch("status", out_mon.status, w.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) link_tbl[i] = LINK_EMPTY;
      link_tbl[0] = LINK_END;
      hint   = 1;
      unused = NUM_BLOCKS - 1;
      awaited_results.delete();
    end else begin
      // The result is checked before this edge's request is queued behind it.
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.func, in_mon.block_index, in_mon.link_value);
    end
    error_count     <= errs;
    pending_results <= awaited_results.size();
  end

  initial begin
    errs      = 0;
    result_no = 0;
  end

endmodule

// ===== tb/fat_chain_block_allocator_test.sv =====
// Top of the block allocator testbench: clock, reset, request and result handshakes,
// directed and random stimulus, back-pressure and the verdict.
// Depends on fcba_pkg, fcba_if, fat_chain_block_allocator and fcba_result_checker.
`timescale 1ns / 1ps

module fat_chain_block_allocator_test;
  import fcba_pkg::*;

  // The cycle limit leaves ample room for the slowest correct run: the clearing pass,
  // about seven hundred transfers under heavy idling, and walks and scans bounded by
  // the few hundred entries that are ever filled.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 700;

  logic clk = 1'b0;
  logic rst_n;

  fcba_in_if  in_chan ();
  fcba_out_if out_chan ();

  int error_count;
  int pending_results;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int items_sent;
  int cycle_count;

  fat_chain_block_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fcba_result_checker result_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fat_chain_block_allocator_test: errors");
    $finish;
  end

  // Receiver: ready is redrawn every cycle from the current idle rate. A hold-off
  // request keeps ready low for that many cycles so that the block backs up and
  // stops taking requests while the sender keeps offering them.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        hold_cycles    = hold_cycles - 1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One request transfer. Idle cycles come first, so valid stays high between
  // back-to-back requests and is never lowered and raised in the same step.
  task automatic send_req(input logic [1:0] op, input logic [15:0] idx,
                          input logic [15:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= op;
    in_chan.block_index <= idx;
    in_chan.link_value  <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  // Lowers valid after the last transfer and waits until every expected result has
  // come. The first edge lets the checker count a request taken at the last edge.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Indexes lean towards the low blocks where chains are built, with the bad index,
  // the top of the table and the whole 16-bit range mixed in.
  function automatic logic [15:0] pick_index();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'hFFFE;
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_link();
    case ($urandom_range(9))
      0:       return LINK_EMPTY;
      1:       return LINK_END;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  // A well-formed sequence: link a few low blocks into a chain ending in the end
  // marker, perhaps allocate on the way, look at one link and usually free the chain.
  // Blocks may repeat, which makes loops and chains that share entries.
  task automatic chain_episode();
    logic [15:0] blk [6];
    int          len;
    int          base;
    int          i;
    len  = $urandom_range(1, 6);
    base = $urandom_range(1, 200);
    for (i = 0; i < len; i++) blk[i] = 16'(base + $urandom_range(0, 40));
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_req(FUNC_ALLOC, pick_index(), pick_link());
    for (i = 0; i < len - 1; i++) send_req(FUNC_SET, blk[i], blk[i+1]);
    send_req(FUNC_SET, blk[len-1], LINK_END);
    if ($urandom_range(1) == 0) send_req(FUNC_READ, blk[$urandom_range(len - 1)], pick_link());
    if ($urandom_range(9) != 0) send_req(FUNC_FREE, blk[0], pick_link());
  endtask

  task automatic noise_item();
    send_req(2'($urandom), pick_index(), pick_link());
  endtask

  task automatic random_until(input int last_item);
    while (items_sent < last_item) begin
      if ($urandom_range(9) < 6) chain_episode();
      else noise_item();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.func        = FUNC_READ;
    in_chan.block_index = 16'd0;
    in_chan.link_value  = 16'd0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    hold_cycles         = 0;
    items_sent          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The block clears its table after reset and holds ready low
    // meanwhile, so the first transfer simply waits for it.
    send_req(FUNC_READ,  16'd0,     16'hFFFF);   // bad index: block 0 is reserved
    send_req(FUNC_READ,  16'hFFFF,  16'h0000);   // last block, in range and empty
    send_req(FUNC_FREE,  16'd0,     16'h0000);   // bad index on free
    send_req(FUNC_SET,   16'd0,     16'hFFFF);   // bad index on set leaves block 0 alone
    send_req(FUNC_ALLOC, 16'd0,     16'h0000);   // hands out 1
    send_req(FUNC_ALLOC, 16'd1,     16'h0000);   // hands out 2, reads link of block 1
    send_req(FUNC_ALLOC, 16'hFFFF,  16'h0000);   // hands out 3
    send_req(FUNC_SET,   16'd1,     16'd2);      // chain 1 -> 2 -> 3 -> end
    send_req(FUNC_SET,   16'd2,     16'd3);
    send_req(FUNC_FREE,  16'd1,     16'h0000);   // walk stops at the end marker
    send_req(FUNC_SET,   16'd5,     16'd6);      // 6 is empty
    send_req(FUNC_FREE,  16'd5,     16'h0000);   // walk stops at an empty entry
    send_req(FUNC_SET,   16'd10,    16'd11);     // a two-block loop
    send_req(FUNC_SET,   16'd11,    16'd10);
    send_req(FUNC_FREE,  16'd10,    16'h0000);   // the loop ends on the emptied head
    send_req(FUNC_SET,   16'd1,     16'h5555);   // set at the hint moves the hint on
    send_req(FUNC_SET,   16'd1,     16'hAAAA);   // non-empty over non-empty
    send_req(FUNC_SET,   16'd1,     LINK_EMPTY); // emptying lowers the hint again
    send_req(FUNC_SET,   16'hFFFF,  LINK_END);
    send_req(FUNC_READ,  16'hFFFF,  16'h0000);
    send_req(FUNC_FREE,  16'hFFFF,  16'h0000);
    send_req(FUNC_SET,   16'd20,    16'hFFFE);   // points far up the table
    send_req(FUNC_FREE,  16'd20,    16'h0000);
    send_req(FUNC_ALLOC, 16'd20,    16'hFFFF);
    wait_drained();

    // Random part in three phases of idling: a slow receiver, then a slow sender,
    // then neither. Early on the receiver holds off for a long stretch while the
    // sender keeps going, and the sender pauses for a full drain between phases.
    send_idle_pct = 21;
    recv_idle_pct = 61;
    random_until(items_sent + 100);
    hold_cycles = 400;
    random_until(items_sent + 30);
    random_until(RANDOM_ITEMS / 3 + 24);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 21;
    random_until(2 * RANDOM_ITEMS / 3 + 24);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_until(RANDOM_ITEMS + 24);
    wait_drained();

    // Nothing is in work now; a short wait catches any stray result.
    repeat (64) @(posedge clk);
    if (error_count == 0 && pending_results == 0) begin
      $display("fat_chain_block_allocator_test: clean");
    end else begin
      $display("fat_chain_block_allocator_test: errors");
    end
    $finish;
  end

endmodule
